// ----- rtl/brbs_pkg.sv -----
// Shared types and constants for the bitmap range bit search core.
// No dependencies; imported by brbs_word_scan and bitmap_range_bit_search_core.

package brbs_pkg;

    localparam int unsigned POS_W     = 14;   // bit position width
    localparam int unsigned IDX_W     = 8;    // word_index width
    localparam int unsigned WORD_W    = 32;   // bitmap word width
    localparam int unsigned OFF_W     = 5;    // bit offset inside a word
    localparam int unsigned WSEL_W    = POS_W - OFF_W;  // word number of a position
    localparam int unsigned OP_W      = 2;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_WRITE     = 2'd0,
        OP_FIND_SET  = 2'd1,
        OP_FIND_CLR  = 2'd2,
        OP_NONE      = 2'd3
    } op_t;

    // Control of the word scan unit for one word.
    typedef struct packed {
        logic             want_set;  // look for ones, else for zeros
        logic             use_lo;    // word holds the first bit: mask below lo_off
        logic [OFF_W-1:0] lo_off;
        logic             use_hi;    // word holds the last bit: mask above hi_off
        logic [OFF_W-1:0] hi_off;
    } scan_ctl_t;

endpackage

// ----- rtl/bitmap_range_bit_search_core.sv -----
// Top level of the bitmap range bit search core: bitmap memory, scan sequencer
// and stream ports. Depends on brbs_pkg and brbs_word_scan.
//
//  Channel  | Dir | Ports                        | Request content
//  ---------+-----+------------------------------+--------------------------------------
//  s_       | in  | s_tvalid s_tready s_tdata    | write word or find set/clear bit
//           |     | s_tuser                      |
//  m_       | out | m_tvalid m_tready m_tdata    | position and found flag
//           |     | m_tuser                      |
//
// Sequencing: a write request or an unused op is accepted and then presents its
// result; an empty search range likewise. A search walks the bitmap one word per
// cycle through the single read port of the bitmap memory, each read word being
// registered before it is checked.
// Reset clears the sequencer only; the bitmap holds garbage until written.
// The input is not ready while a request is in flight; a stalled result holds
// in the output register until m_tready.

module bitmap_range_bit_search_core #(
    parameter int unsigned BITMAP_WORDS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request: s_tdata = word_index[7:0], word_data[39:8], first_bit[53:40],
    //          stop_bit[67:54], zero pad [71:68]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic [1:0]  s_tuser,   // op[1:0]
    // result
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // position[13:0], zero pad [15:14]
    output logic [0:0]  m_tuser    // found[0]
);
    import brbs_pkg::*;

    localparam int unsigned AW        = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int unsigned LIMIT     = BITMAP_WORDS * WORD_W;
    localparam int unsigned END_W     = POS_W + 1;
    // Positions never exceed 14 bits, so a bitmap past that size clips nothing.
    localparam logic [END_W-1:0] LIMIT_C =
        (LIMIT > (1 << POS_W)) ? END_W'(1 << POS_W) : END_W'(LIMIT);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Unpack request fields.
    op_t               in_op;
    logic [IDX_W-1:0]  in_index;
    logic [WORD_W-1:0] in_data;
    logic [POS_W-1:0]  in_first;
    logic [POS_W-1:0]  in_stop;

    assign in_op    = op_t'(s_tuser);
    assign in_index = s_tdata[7:0];
    assign in_data  = s_tdata[39:8];
    assign in_first = s_tdata[53:40];
    assign in_stop  = s_tdata[67:54];

    // Sequencer state and payload registers.
    state_t            state_reg, state_next;
    logic              chk_valid_reg, chk_valid_next;
    logic [WSEL_W-1:0] rd_word_reg, rd_word_next;
    logic [WSEL_W-1:0] chk_word_reg, chk_word_next;
    logic [WSEL_W-1:0] first_word_reg, first_word_next;
    logic [OFF_W-1:0]  first_off_reg, first_off_next;
    logic [WSEL_W-1:0] last_word_reg, last_word_next;
    logic [OFF_W-1:0]  last_off_reg, last_off_next;
    logic              want_set_reg, want_set_next;
    logic [POS_W-1:0]  miss_pos_reg, miss_pos_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              found_reg, found_next;

    // Bitmap memory.
    logic [WORD_W-1:0] bitmap_mem [BITMAP_WORDS];
    logic [WORD_W-1:0] rdata_reg;
    logic              wr_en;

    // Search bounds derived at accept time.
    logic [END_W-1:0]  stop_ext;
    logic [END_W-1:0]  end_pos;
    logic [END_W-1:0]  end_last;
    logic [END_W-1:0]  stop_inc;
    logic [POS_W-1:0]  miss_pos;
    logic              range_empty;

    scan_ctl_t         scan_ctl;
    logic              scan_hit;
    logic [OFF_W-1:0]  scan_bit;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_DONE);
    assign m_tdata  = {2'b00, pos_reg};
    assign m_tuser  = found_reg;

    assign wr_en = s_tvalid && s_tready && (in_op == OP_WRITE)
                   && (32'(in_index) < BITMAP_WORDS);

    // Write on accepted write requests with an index inside the bitmap, read one word per cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            bitmap_mem[AW'(in_index)] <= in_data;
        end
        rdata_reg <= bitmap_mem[AW'(rd_word_reg)];
    end

    // Clip the range to the bitmap and precompute the no-match answer.
    always_comb begin
        stop_ext    = END_W'(in_stop);
        end_pos     = (stop_ext < LIMIT_C) ? stop_ext : LIMIT_C;
        range_empty = (END_W'(in_first) >= end_pos);
        end_last    = end_pos - END_W'(1);
        stop_inc    = stop_ext + END_W'(1);
        miss_pos    = stop_inc[POS_W] ? POS_MAX : stop_inc[POS_W-1:0];
    end

    always_comb begin
        scan_ctl.want_set = want_set_reg;
        scan_ctl.use_lo   = (chk_word_reg == first_word_reg);
        scan_ctl.lo_off   = first_off_reg;
        scan_ctl.use_hi   = (chk_word_reg == last_word_reg);
        scan_ctl.hi_off   = last_off_reg;
    end

    brbs_word_scan u_scan (
        .word_data (rdata_reg),
        .ctl       (scan_ctl),
        .hit       (scan_hit),
        .hit_bit   (scan_bit)
    );

    always_comb begin
        state_next      = state_reg;
        chk_valid_next  = chk_valid_reg;
        rd_word_next    = rd_word_reg;
        chk_word_next   = chk_word_reg;
        first_word_next = first_word_reg;
        first_off_next  = first_off_reg;
        last_word_next  = last_word_reg;
        last_off_next   = last_off_reg;
        want_set_next   = want_set_reg;
        miss_pos_next   = miss_pos_reg;
        pos_next        = pos_reg;
        found_next      = found_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (in_op) inside
                        OP_FIND_SET, OP_FIND_CLR: begin
                            want_set_next   = (in_op == OP_FIND_SET);
                            miss_pos_next   = miss_pos;
                            first_word_next = in_first[POS_W-1:OFF_W];
                            first_off_next  = in_first[OFF_W-1:0];
                            last_word_next  = end_last[POS_W-1:OFF_W];
                            last_off_next   = end_last[OFF_W-1:0];
                            rd_word_next    = in_first[POS_W-1:OFF_W];
                            chk_valid_next  = 1'b0;
                            if (range_empty) begin
                                pos_next   = miss_pos;
                                found_next = 1'b0;
                                state_next = ST_DONE;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        default: begin
                            // Write or unused op: answer position zero, not found.
                            pos_next   = '0;
                            found_next = 1'b0;
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // Advance the read address; the checked word is the address read in the cycle before.
                rd_word_next   = rd_word_reg + WSEL_W'(1);
                chk_word_next  = rd_word_reg;
                chk_valid_next = 1'b1;
                if (chk_valid_reg) begin
                    if (scan_hit) begin
                        pos_next   = {chk_word_reg, scan_bit};
                        found_next = 1'b1;
                        state_next = ST_DONE;
                    end else if (chk_word_reg == last_word_reg) begin
                        pos_next   = miss_pos_reg;
                        found_next = 1'b0;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                // Hold the result until taken.
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        rd_word_reg    <= rd_word_next;
        chk_word_reg   <= chk_word_next;
        first_word_reg <= first_word_next;
        first_off_reg  <= first_off_next;
        last_word_reg  <= last_word_next;
        last_off_reg   <= last_off_next;
        want_set_reg   <= want_set_next;
        miss_pos_reg   <= miss_pos_next;
        pos_reg        <= pos_next;
        found_reg      <= found_next;
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            chk_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

endmodule

// ----- rtl/brbs_word_scan.sv -----
// Word scan unit: masks one bitmap word to the search range and finds the
// lowest matching bit. Depends on brbs_pkg.

module brbs_word_scan (
    input  logic [brbs_pkg::WORD_W-1:0] word_data,
    input  brbs_pkg::scan_ctl_t         ctl,
    output logic                        hit,
    output logic [brbs_pkg::OFF_W-1:0]  hit_bit
);
    import brbs_pkg::*;

    logic [WORD_W-1:0] cand;

    always_comb begin
        for (int b = 0; b < WORD_W; b++) begin
            cand[b] = (ctl.want_set ? word_data[b] : ~word_data[b])
                      && (!ctl.use_lo || (OFF_W'(b) >= ctl.lo_off))
                      && (!ctl.use_hi || (OFF_W'(b) <= ctl.hi_off));
        end
    end

    // Lowest set bit of the candidate vector.
    always_comb begin
        hit     = |cand;
        hit_bit = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (cand[b]) begin
                hit_bit = OFF_W'(b);
            end
        end
    end

endmodule
